@@ src/pva_pkg.sv @@
// Shared types and constants of the polyphonic voice allocator.
package pva_pkg;

  // Default number of voices.
  localparam int NumVoicesDef = 8;

  // Channel tag that marks a voice with no channel.
  localparam logic [6:0] NoChannel = 7'h7F;

  // Note code ranges.
  localparam logic [7:0] NoteTop     = 8'd119;
  localparam logic [7:0] NoteRelease = 8'd120;

  // Envelope state of one voice.
  typedef enum logic [1:0] {
    ENV_IDLE    = 2'd0,
    ENV_ACTIVE  = 2'd1,
    ENV_RELEASE = 2'd2
  } env_e;

  // Command sent to a voice.
  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_RELEASE = 1'b1
  } action_e;

  // Kind of input item.
  typedef enum logic {
    REQ_NOTE     = 1'b0,
    REQ_FINISHED = 1'b1
  } req_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_START
  } state_e;

  // One entry of the voice memory.
  typedef struct packed {
    logic [6:0] chan;
    env_e       env;
  } voice_entry_t;

  localparam voice_entry_t VoiceReset = '{chan: NoChannel, env: ENV_IDLE};

  // One outgoing voice command.
  typedef struct packed {
    logic [2:0] voice_index;
    action_e    action;
    logic [6:0] pitch;
    logic       last;
  } result_t;

endpackage

@@ src/pva_voice_mem.sv @@
// Voice state memory with one read and one write port and per-entry valid bits.
module pva_voice_mem import pva_pkg::*; #(
  parameter int NUM_VOICES = NumVoicesDef,
  parameter int AW         = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output voice_entry_t  rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  voice_entry_t  wr_data_i
);

  voice_entry_t            mem_q [NUM_VOICES];
  logic [NUM_VOICES-1:0]   valid_q;
  voice_entry_t            rdata_q;
  logic                    rvalid_q;

  // Storage array, written at one address per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits: an entry never written reads as the reset entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : VoiceReset;

  // The sequencer never reads and writes the same entry in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_i && wr_en_i) |-> (rd_addr_i != wr_addr_i))
    else $error("voice memory read and write collide on one entry");

endmodule

@@ src/pva_scan.sv @@
// Sequencer that scans the voice memory and emits voice commands.
module pva_scan import pva_pkg::*; #(
  parameter int NUM_VOICES = NumVoicesDef,
  parameter int AW         = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Incoming item
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  req_e          req_i,
  input  logic [5:0]    chan_i,
  input  logic [7:0]    note_i,
  input  logic [2:0]    fin_i,
  input  logic          glide_i,
  // Voice memory
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  input  voice_entry_t  rd_data_i,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output voice_entry_t  wr_data_o,
  // Outgoing commands
  output logic          res_valid_o,
  output result_t       res_o,
  input  logic          res_room_i
);

  localparam logic [AW-1:0] LastVoice = AW'(NUM_VOICES - 1);

  state_e        state_q, state_d;
  req_e          req_q;
  logic [5:0]    chan_q;
  logic [7:0]    note_q;
  logic [AW-1:0] fin_q;
  logic [AW-1:0] v_q, v_d;
  logic [AW-1:0] use_q, use_d;
  logic          have_q, have_d;
  logic          use_on_q, use_on_d;

  logic          accept;
  logic          fin_ok;
  logic          is_on;
  logic          is_off;
  logic          on_ch;
  logic          env_idle;
  logic          env_rel;
  logic          last_voice;
  logic          off_match;
  logic          step_done;

  assign accept     = in_valid_i && in_ready_o;
  assign fin_ok     = 32'(fin_i) < 32'(NUM_VOICES);
  assign is_on      = note_q <= NoteTop;
  assign is_off     = note_q == NoteRelease;
  assign on_ch      = rd_data_i.chan == {1'b0, chan_q};
  assign env_idle   = rd_data_i.env == ENV_IDLE;
  assign env_rel    = rd_data_i.env == ENV_RELEASE;
  assign last_voice = v_q == LastVoice;
  assign off_match  = on_ch && !env_idle && !env_rel;

  // A scan step on a note-on waits only when it must emit and the output is full.
  assign step_done  = !(on_ch && !glide_i) || res_room_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i == REQ_FINISHED) begin
            state_d = fin_ok ? ST_PRIME : ST_IDLE;
          end else if (note_i <= NoteTop || note_i == NoteRelease) begin
            state_d = ST_PRIME;
          end
        end
      end
      ST_PRIME: state_d = ST_SCAN;
      ST_SCAN: begin
        if (req_q == REQ_FINISHED) begin
          state_d = ST_IDLE;
        end else if (is_on) begin
          if (step_done && last_voice) begin
            state_d = ST_START;
          end
        end else if (is_off) begin
          if (off_match) begin
            if (res_room_i) begin
              state_d = ST_IDLE;
            end
          end else if (last_voice) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_START: begin
        if (res_room_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory accesses, scan bookkeeping and command emission.
  always_comb begin
    in_ready_o  = 1'b0;
    rd_en_o     = 1'b0;
    rd_addr_o   = v_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = v_q;
    wr_data_o   = VoiceReset;
    res_valid_o = 1'b0;
    res_o       = '{voice_index: 3'(v_q), action: ACT_RELEASE, pitch: 7'd0, last: 1'b0};
    v_d         = v_q;
    use_d       = use_q;
    have_d      = have_q;
    use_on_d    = use_on_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          v_d      = '0;
          use_d    = '0;
          have_d   = 1'b0;
          use_on_d = 1'b0;
        end
      end
      ST_PRIME: begin
        rd_en_o   = 1'b1;
        rd_addr_o = (req_q == REQ_FINISHED) ? fin_q : v_q;
      end
      ST_SCAN: begin
        if (req_q == REQ_FINISHED) begin
          // Envelope ended: idle, channel tag kept.
          wr_en_o   = 1'b1;
          wr_addr_o = fin_q;
          wr_data_o = '{chan: rd_data_i.chan, env: ENV_IDLE};
        end else if (is_on) begin
          if (step_done) begin
            // Preferred free voice.
            if (env_idle && (!have_q || !use_on_q || !glide_i)) begin
              use_d    = v_q;
              have_d   = 1'b1;
              use_on_d = on_ch;
            end else if (env_rel && !have_q) begin
              use_d    = v_q;
              have_d   = 1'b1;
              use_on_d = on_ch;
            end
            // A voice already on this channel.
            if (on_ch) begin
              if (!glide_i) begin
                res_valid_o = 1'b1;
                wr_en_o     = 1'b1;
                wr_data_o   = '{chan: NoChannel,
                                env: env_idle ? ENV_IDLE : ENV_RELEASE};
                if (!have_d) begin
                  use_d    = v_q;
                  have_d   = 1'b1;
                  use_on_d = 1'b1;
                end
              end else begin
                use_d    = v_q;
                have_d   = 1'b1;
                use_on_d = 1'b1;
              end
            end
            if (!last_voice) begin
              v_d       = v_q + 1'b1;
              rd_en_o   = 1'b1;
              rd_addr_o = v_q + 1'b1;
            end
          end else begin
            // Output full: reread the same voice.
            rd_en_o = 1'b1;
          end
        end else if (is_off) begin
          if (off_match) begin
            if (res_room_i) begin
              res_valid_o = 1'b1;
              res_o.last  = 1'b1;
              wr_en_o     = 1'b1;
              wr_data_o   = '{chan: NoChannel, env: ENV_RELEASE};
            end else begin
              rd_en_o = 1'b1;
            end
          end else if (!last_voice) begin
            v_d       = v_q + 1'b1;
            rd_en_o   = 1'b1;
            rd_addr_o = v_q + 1'b1;
          end
        end
      end
      ST_START: begin
        if (res_room_i) begin
          res_valid_o = 1'b1;
          res_o       = '{voice_index: 3'(use_q), action: ACT_START,
                          pitch: note_q[6:0], last: 1'b1};
          wr_en_o     = 1'b1;
          wr_addr_o   = use_q;
          wr_data_o   = '{chan: {1'b0, chan_q}, env: ENV_ACTIVE};
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      v_q      <= '0;
      use_q    <= '0;
      have_q   <= 1'b0;
      use_on_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      v_q      <= v_d;
      use_q    <= use_d;
      have_q   <= have_d;
      use_on_q <= use_on_d;
    end
  end

  // Captured item fields.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_i;
      chan_q <= chan_i;
      note_q <= note_i;
      fin_q  <= AW'(fin_i);
    end
  end

  // A command is produced only when the output stage can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_room_i)
    else $error("command emitted without room in the output stage");

  // No memory write while waiting for an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !wr_en_o)
    else $error("voice memory written while idle");

  // A start command always closes the commands of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.action == ACT_START) |-> res_o.last)
    else $error("start command not marked last");

endmodule

@@ src/pva_out_reg.sv @@
// Output register stage for voice commands.
module pva_out_reg import pva_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    res_room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign res_room_o = !valid_q || out_ready_i;

  // Holding flag: set on a new command, cleared when taken.
  always_comb begin
    valid_d = valid_q;
    if (res_room_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload is loaded only when a command enters.
  always_ff @(posedge clk_i) begin
    if (res_room_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ src/poly_voice_allocator.sv @@
// Polyphonic voice allocator: assigns note events to voices whose state lives in one memory.
// Each input item is one note event or one voice-finished event. A voice-finished item passes
// through accept, memory read and write back. A note is handled by a scan of the voice memory,
// which has a single read port and is walked one voice per cycle; the scan holds a voice
// while its command cannot enter the full output register. Ignored note codes and finished
// voices beyond the voice count are accepted with no command.
// After reset every voice is idle with no channel; no clearing pass is needed.
module poly_voice_allocator import pva_pkg::*; #(
  parameter int NUM_VOICES = NumVoicesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: glide setting, zero means glide off
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  // Incoming note items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // channel[5:0], note_code[13:6], finished_voice[16:14]
  input  logic [0:0]  s_axis_tuser,  // req_type[0]
  // Outgoing voice commands
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // voice_index[2:0], action[3], pitch[10:4]
  output logic        m_axis_tlast
);

  localparam int AW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  logic [6:0]   glide_q;
  logic         rd_en;
  logic [AW-1:0] rd_addr;
  voice_entry_t rd_data;
  logic         wr_en;
  logic [AW-1:0] wr_addr;
  voice_entry_t wr_data;
  logic         res_valid;
  result_t      res;
  logic         res_room;
  result_t      out_data;

  // Glide register, written whenever offered.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glide_q <= 7'd0;
    end else if (cfg_valid_i) begin
      glide_q <= cfg_data_i;
    end
  end

  pva_voice_mem #(
    .NUM_VOICES(NUM_VOICES),
    .AW        (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  pva_scan #(
    .NUM_VOICES(NUM_VOICES),
    .AW        (AW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .req_i      (req_e'(s_axis_tuser[0])),
    .chan_i     (s_axis_tdata[5:0]),
    .note_i     (s_axis_tdata[13:6]),
    .fin_i      (s_axis_tdata[16:14]),
    .glide_i    (glide_q != 7'd0),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_room_i (res_room)
  );

  pva_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .res_room_o (res_room),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_data)
  );

  assign m_axis_tdata = {5'd0, out_data.pitch, out_data.action, out_data.voice_index};
  assign m_axis_tlast = out_data.last;

endmodule
